### src/hashed_timing_wheel_unit_defines.svh
// Assertion macros shared by the timing wheel checker.
// No dependencies; include once per file that asserts.
`ifndef HASHED_TIMING_WHEEL_UNIT_DEFINES_SVH
`define HASHED_TIMING_WHEEL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HWU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hwu check failed");

// Next-cycle implication, disabled while reset is low.
`define HWU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hwu check failed");

`endif

### src/hwu_pkg.sv
// Shared widths, codes and types of the hashed timing wheel.
// No dependencies; used by the divider, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package hwu_pkg;

    localparam int CMD_W       = 2;
    localparam int DELAY_W     = 31;
    localparam int ID_W        = 16;
    localparam int KIND_W      = 3;
    localparam int SLOT_W      = 8;
    localparam int ROUNDS_W    = 31;
    localparam int SLOT_CNT_W  = 9;
    localparam int PERIOD_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 56;

    localparam int MAX_SLOTS          = 256;
    localparam int MAX_TIMERS_DEFAULT = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK_NONE = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD = 1'd1;

    localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RESET  = 9'd256;
    localparam logic [PERIOD_W-1:0]   TICK_PERIOD_RESET = 16'd1;
    localparam logic [ID_W-1:0]       ID_FIRST          = 16'd1;
    localparam logic [ID_W-1:0]       ID_LAST           = 16'hFFFF;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [SLOT_W-1:0]   slot;
        logic [ROUNDS_W-1:0] rounds;
    } entry_t;

    typedef struct packed {
        logic                start;
        logic [DELAY_W-1:0]  dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DELAY_W-1:0]  quotient;
        logic [PERIOD_W-1:0] remainder;
    } div_rsp_t;

endpackage

### src/hwu_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on hwu_pkg (div_req_t, div_rsp_t, widths).
`timescale 1ns / 1ps

module hwu_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  hwu_pkg::div_req_t req,
    output hwu_pkg::div_rsp_t rsp
);

    localparam int QW     = hwu_pkg::DELAY_W;
    localparam int RW     = hwu_pkg::PERIOD_W;
    localparam int STEP_W = $clog2(QW);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QW - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [QW-1:0]     quo_reg;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     divisor_reg;

    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[QW-2:0], fits};
            rem_reg <= fits ? diff[RW-1:0] : trial[RW-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### src/hashed_timing_wheel_unit.sv
// Top level of the single-level hashed timing wheel.
// Depends on hwu_pkg and hwu_divider; timer table held in a local RAM.
`timescale 1ns / 1ps
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------------
//  s_       in   s_tvalid/s_tready  tuser: command; tdata: delay_ms, timer_id
//  m_       out  m_tvalid/m_tready  tuser: kind; tdata: id, slot, rounds; tlast
//  cfg_     in   cfg_wr_en          cfg_index selects register, cfg_wr_data
//
//  Add: two serial divides, plus a third divide for the modulo when the slot
//  pointer sits beyond a shrunk slot count. Cancel and tick: a scan of the
//  live timers, one table entry per cycle through the single RAM read port
//  unless m_ stalls a tick's scan; a tick adds a divide when the pointer needs a
//  full modulo. One item is in flight at a time; s_tready is high only idle.
//  Reset (aresetn low, synchronous) empties the table, pointer 0, next id 1.
//  A stalled m_ side holds the scan whenever a second fired timer is found.

module hashed_timing_wheel_unit #(
    parameter int MAX_TIMERS = hwu_pkg::MAX_TIMERS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hwu_pkg::S_TDATA_W-1:0]      s_tdata,   // delay_ms[30:0], timer_id[46:31]
    input  logic [hwu_pkg::CMD_W-1:0]          s_tuser,   // command
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hwu_pkg::M_TDATA_W-1:0]      m_tdata,   // id[15:0], slot[23:16], rounds[54:24]
    output logic [hwu_pkg::KIND_W-1:0]         m_tuser,   // kind
    output logic                               m_tlast,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [hwu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hwu_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int SW    = hwu_pkg::SLOT_W;
    localparam int SCW   = hwu_pkg::SLOT_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TICKS,     // delay / period
        ST_DIV_SLOTS,     // ticks / slots
        ST_DIV_SLOT_MOD,  // (pointer + ticks mod slots) mod slots, slow path
        ST_SCAN,          // walk the table, compact in place
        ST_FINISH,        // final result and commit
        ST_DIV_PTR_MOD    // (pointer + 1) mod slots, slow path
    } state_t;

    // ---------------- configuration ----------------
    logic [SCW-1:0]               slot_count_reg;
    logic [hwu_pkg::PERIOD_W-1:0] tick_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg  <= hwu_pkg::SLOT_COUNT_RESET;
            tick_period_reg <= hwu_pkg::TICK_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hwu_pkg::REG_SLOT_COUNT:  slot_count_reg  <= cfg_wr_data[SCW-1:0];
                hwu_pkg::REG_TICK_PERIOD: tick_period_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [SCW-1:0]               slots_eff;
    logic [hwu_pkg::PERIOD_W-1:0] period_eff;

    // zero slots acts as one, oversize clamps to the wheel size
    assign slots_eff  = (slot_count_reg == '0) ? SCW'(1) :
                        (slot_count_reg > SCW'(hwu_pkg::MAX_SLOTS)) ?
                        SCW'(hwu_pkg::MAX_SLOTS) : slot_count_reg;
    assign period_eff = (tick_period_reg == '0) ? hwu_pkg::PERIOD_W'(1) : tick_period_reg;

    // ---------------- state ----------------
    state_t                        state_reg;
    logic [hwu_pkg::CMD_W-1:0]     op_reg;
    logic                          full_reg;
    logic [CNT_W-1:0]              count_reg;     // live timers, packed at low indexes
    logic [SW-1:0]                 cur_slot_reg;
    logic [hwu_pkg::ID_W-1:0]      next_id_reg;
    logic [CNT_W-1:0]              rd_idx_reg;
    logic [CNT_W-1:0]              wr_idx_reg;
    logic                          found_reg;
    logic                          hold_valid_reg; // newest fired timer, waits for its last flag
    logic [hwu_pkg::ID_W-1:0]      hold_id_reg;
    logic [hwu_pkg::ID_W-1:0]      tid_reg;
    logic [hwu_pkg::ROUNDS_W-1:0]  rounds_reg;
    logic [SW-1:0]                 add_slot_reg;

    logic                          out_valid_reg;
    logic [hwu_pkg::KIND_W-1:0]    out_kind_reg;
    logic [hwu_pkg::ID_W-1:0]      out_id_reg;
    logic [SW-1:0]                 out_slot_reg;
    logic [hwu_pkg::ROUNDS_W-1:0]  out_rounds_reg;
    logic                          out_last_reg;

    // timer table
    hwu_pkg::entry_t mem [MAX_TIMERS];
    hwu_pkg::entry_t mem_q;
    logic            mem_we;
    logic            mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    hwu_pkg::entry_t mem_wdata;

    hwu_pkg::div_req_t div_req;
    hwu_pkg::div_rsp_t div_rsp;

    hwu_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- input decode ----------------
    logic [hwu_pkg::DELAY_W-1:0] in_delay;
    logic [hwu_pkg::ID_W-1:0]    in_tid;
    logic                        accept;
    logic                        add_full;

    assign in_delay = s_tdata[hwu_pkg::DELAY_W-1:0];
    assign in_tid   = s_tdata[hwu_pkg::DELAY_W +: hwu_pkg::ID_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign add_full = count_reg >= CNT_W'(MAX_TIMERS);

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // ---------------- slot arithmetic ----------------
    logic [SCW-1:0] cur_ext;
    logic           cur_in_range;
    logic [SCW-1:0] slot_sum;
    logic [SCW-1:0] slot_wrapped;
    logic [SCW-1:0] ptr_inc;
    logic [SCW-1:0] ptr_wrapped;

    assign cur_ext      = {1'b0, cur_slot_reg};
    assign cur_in_range = cur_ext < slots_eff;
    // remainder by slots is below 256, so the low byte carries it
    assign slot_sum     = cur_ext + {1'b0, div_rsp.remainder[SW-1:0]};
    assign slot_wrapped = (slot_sum >= slots_eff) ? slot_sum - slots_eff : slot_sum;
    assign ptr_inc      = cur_ext + SCW'(1);
    assign ptr_wrapped  = (ptr_inc == slots_eff) ? '0 : ptr_inc;

    // ---------------- scan decisions ----------------
    logic             is_tick;
    logic             slot_hit;
    logic             fire;
    logic             cancel_hit;
    logic             drop;
    logic             stall;
    logic             scan_step;
    logic             scan_start;
    logic             scan_last;
    logic [CNT_W-1:0] rd_next;
    logic             add_commit;

    assign is_tick    = (op_reg == hwu_pkg::CMD_TICK);
    assign slot_hit   = (mem_q.slot == cur_slot_reg);
    assign fire       = is_tick && slot_hit && (mem_q.rounds == '0);
    // oldest live match only
    assign cancel_hit = !is_tick && !found_reg && (mem_q.id == tid_reg);
    assign drop       = fire || cancel_hit;
    // a second fire must push the held one out first
    assign stall      = fire && hold_valid_reg && !out_free;
    assign scan_step  = (state_reg == ST_SCAN) && !stall;
    assign rd_next    = rd_idx_reg + CNT_W'(1);
    assign scan_last  = (rd_next == count_reg);
    assign scan_start = accept && ((s_tuser == hwu_pkg::CMD_CANCEL) ||
                                   (s_tuser == hwu_pkg::CMD_TICK)) && (count_reg != '0);
    assign add_commit = (state_reg == ST_FINISH) && out_free &&
                        (op_reg == hwu_pkg::CMD_ADD) && !full_reg;

    always_comb begin
        mem_re    = scan_start || (scan_step && !scan_last);
        mem_raddr = scan_start ? '0 : rd_next[IDX_W-1:0];
        mem_we    = (scan_step && !drop) || add_commit;
        mem_waddr = add_commit ? count_reg[IDX_W-1:0] : wr_idx_reg[IDX_W-1:0];
        if (add_commit) begin
            mem_wdata.id     = next_id_reg;
            mem_wdata.slot   = add_slot_reg;
            mem_wdata.rounds = rounds_reg;
        end else begin
            // kept entry moves down to the write pointer
            mem_wdata = mem_q;
            if (is_tick && slot_hit) begin
                mem_wdata.rounds = mem_q.rounds - hwu_pkg::ROUNDS_W'(1);
            end
        end
    end

    // write index never passes the read index, so no forwarding is needed
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
        end
    end

    // ---------------- divider requests ----------------
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == hwu_pkg::CMD_ADD) && !add_full) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = in_delay;
                    div_req.divisor  = period_eff;
                end
            end
            ST_DIV_TICKS: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = div_rsp.quotient;
                div_req.divisor  = hwu_pkg::PERIOD_W'(slots_eff);
            end
            ST_DIV_SLOTS: begin
                div_req.start    = div_rsp.done && !cur_in_range;
                div_req.dividend = hwu_pkg::DELAY_W'(slot_sum);
                div_req.divisor  = hwu_pkg::PERIOD_W'(slots_eff);
            end
            ST_FINISH: begin
                div_req.start    = out_free && is_tick && !cur_in_range;
                div_req.dividend = hwu_pkg::DELAY_W'(ptr_inc);
                div_req.divisor  = hwu_pkg::PERIOD_W'(slots_eff);
            end
            default: ;
        endcase
    end

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cur_slot_reg   <= '0;
            next_id_reg    <= hwu_pkg::ID_FIRST;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg         <= s_tuser;
                        tid_reg        <= in_tid;
                        full_reg       <= add_full;
                        found_reg      <= 1'b0;
                        hold_valid_reg <= 1'b0;
                        rd_idx_reg     <= '0;
                        wr_idx_reg     <= '0;
                        case (s_tuser) inside
                            hwu_pkg::CMD_ADD:
                                state_reg <= add_full ? ST_FINISH : ST_DIV_TICKS;
                            hwu_pkg::CMD_CANCEL, hwu_pkg::CMD_TICK:
                                state_reg <= (count_reg != '0) ? ST_SCAN : ST_FINISH;
                            default: ; // unused command: dropped
                        endcase
                    end
                end
                ST_DIV_TICKS: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_DIV_SLOTS;
                    end
                end
                ST_DIV_SLOTS: begin
                    if (div_rsp.done) begin
                        rounds_reg <= div_rsp.quotient;
                        if (cur_in_range) begin
                            add_slot_reg <= slot_wrapped[SW-1:0];
                            state_reg    <= ST_FINISH;
                        end else begin
                            state_reg <= ST_DIV_SLOT_MOD;
                        end
                    end
                end
                ST_DIV_SLOT_MOD: begin
                    if (div_rsp.done) begin
                        add_slot_reg <= div_rsp.remainder[SW-1:0];
                        state_reg    <= ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    if (!stall) begin
                        if (fire) begin
                            if (hold_valid_reg) begin
                                out_valid_reg  <= 1'b1;
                                out_kind_reg   <= hwu_pkg::KIND_FIRED;
                                out_id_reg     <= hold_id_reg;
                                out_slot_reg   <= cur_slot_reg;
                                out_rounds_reg <= '0;
                                out_last_reg   <= 1'b0;
                            end
                            hold_id_reg    <= mem_q.id;
                            hold_valid_reg <= 1'b1;
                        end
                        if (cancel_hit) begin
                            found_reg <= 1'b1;
                        end
                        if (!drop) begin
                            wr_idx_reg <= wr_idx_reg + CNT_W'(1);
                        end
                        rd_idx_reg <= rd_next;
                        if (scan_last) begin
                            count_reg <= wr_idx_reg + CNT_W'(!drop);
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_last_reg   <= 1'b1;
                        out_id_reg     <= '0;
                        out_slot_reg   <= '0;
                        out_rounds_reg <= '0;
                        state_reg      <= ST_IDLE;
                        unique case (op_reg)
                            hwu_pkg::CMD_ADD: begin
                                if (full_reg) begin
                                    out_kind_reg <= hwu_pkg::KIND_FULL;
                                end else begin
                                    out_kind_reg   <= hwu_pkg::KIND_ADDED;
                                    out_id_reg     <= next_id_reg;
                                    out_slot_reg   <= add_slot_reg;
                                    out_rounds_reg <= rounds_reg;
                                    count_reg      <= count_reg + CNT_W'(1);
                                    next_id_reg    <= (next_id_reg == hwu_pkg::ID_LAST) ?
                                                      hwu_pkg::ID_FIRST :
                                                      next_id_reg + hwu_pkg::ID_W'(1);
                                end
                            end
                            hwu_pkg::CMD_CANCEL: begin
                                out_kind_reg <= found_reg ? hwu_pkg::KIND_CANCELLED :
                                                            hwu_pkg::KIND_NOT_FOUND;
                            end
                            hwu_pkg::CMD_TICK: begin
                                out_kind_reg   <= hold_valid_reg ? hwu_pkg::KIND_FIRED :
                                                                   hwu_pkg::KIND_TICK_NONE;
                                out_id_reg     <= hold_valid_reg ? hold_id_reg : '0;
                                out_slot_reg   <= cur_slot_reg;
                                hold_valid_reg <= 1'b0;
                                if (cur_in_range) begin
                                    cur_slot_reg <= ptr_wrapped[SW-1:0];
                                end else begin
                                    state_reg <= ST_DIV_PTR_MOD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV_PTR_MOD: begin
                    if (div_rsp.done) begin
                        cur_slot_reg <= div_rsp.remainder[SW-1:0];
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- result port ----------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_rounds_reg, out_slot_reg, out_id_reg};

endmodule

### src/hwu_checker.sv
// Port-level checks of the timing wheel, bound to the top level.
// Depends on hwu_pkg and hashed_timing_wheel_unit_defines.svh.
`timescale 1ns / 1ps
`include "hashed_timing_wheel_unit_defines.svh"

module hwu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [hwu_pkg::CMD_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hwu_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [hwu_pkg::KIND_W-1:0]     m_tuser,
    input logic                           m_tlast
);

    // held result stays put
    `HWU_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // one item at a time: a real command takes the block busy
    `HWU_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser != hwu_pkg::CMD_NONE), !s_tready)

    // only fired timers can be followed by more results of the same item
    `HWU_ASSERT_SAME(a_single, aclk, aresetn, m_tvalid && (m_tuser != hwu_pkg::KIND_FIRED), m_tlast)

    // no kind beyond the defined set
    `HWU_ASSERT_SAME(a_kind, aclk, aresetn, m_tvalid, m_tuser <= hwu_pkg::KIND_TICK_NONE)

    // an empty tick reports no id
    `HWU_ASSERT_SAME(a_none_id, aclk, aresetn, m_tvalid && (m_tuser == hwu_pkg::KIND_TICK_NONE), m_tdata[15:0] == '0)

endmodule

bind hashed_timing_wheel_unit hwu_checker u_hwu_checker (.*);

### tb/hashed_timing_wheel_unit_tb.sv
// Self-checking testbench for the hashed timing wheel unit.
// Needs hwu_pkg and the hashed_timing_wheel_unit RTL; drives the stream ports, predicts results.
`timescale 1ns / 1ps

module hashed_timing_wheel_unit_tb;
    import hwu_pkg::*;

    localparam int WHEEL_DEPTH     = MAX_TIMERS_DEFAULT;
    localparam int RESET_CYCLES    = 9;
    // Three serial divides on an add are the slowest item, so this covers
    // a tick's pointer modulo still in the block before a register write.
    localparam int SETTLE_CYCLES   = 150;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_ITEMS    = 34;

    // One result item as it is checked: kind, id, slot, rounds, tlast.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     id;
        logic [SLOT_W-1:0]   slot;
        logic [ROUNDS_W-1:0] rounds;
        logic                last;
    } wheel_result_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;   // delay_ms, timer_id, zero pad
    logic [CMD_W-1:0]       s_tuser     = CMD_NONE; // command
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // id, slot, rounds, zero pad
    logic [KIND_W-1:0]      m_tuser;            // kind
    logic                   m_tlast;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = REG_SLOT_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    // Predicted wheel: live timers packed low in order of addition.
    logic [ID_W-1:0]        wheel_id [WHEEL_DEPTH];
    int unsigned            wheel_slot [WHEEL_DEPTH];
    int unsigned            wheel_rounds [WHEEL_DEPTH];
    int unsigned            wheel_live    = 0;
    int unsigned            wheel_ptr     = 0;
    logic [ID_W-1:0]        wheel_next_id = ID_FIRST;
    logic [SLOT_CNT_W-1:0]  cfg_slots_q   = SLOT_COUNT_RESET;
    logic [PERIOD_W-1:0]    cfg_period_q  = TICK_PERIOD_RESET;

    wheel_result_t          pending_results [$];
    int unsigned            mismatch_count = 0;

    // Idling knobs, percent per cycle; hold_request starts a long m_ stall.
    int unsigned            send_gap_pct   = 0;
    int unsigned            stall_pct      = 0;
    int unsigned            hold_request   = 0;
    int unsigned            hold_left      = 0;

    hashed_timing_wheel_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void push_result(input logic [KIND_W-1:0] kind,
                                        input logic [ID_W-1:0] id,
                                        input int unsigned slot,
                                        input int unsigned rounds,
                                        input bit last_flag);
        wheel_result_t r;
        r.kind   = kind;
        r.id     = id;
        r.slot   = slot[SLOT_W-1:0];
        r.rounds = rounds[ROUNDS_W-1:0];
        r.last   = last_flag;
        pending_results.push_back(r);
    endfunction

    // Close the gap so live timers stay packed in order of addition.
    function automatic void remove_entry(input int unsigned idx);
        int unsigned j;
        for (j = idx; j + 1 < wheel_live; j++) begin
            wheel_id[j]     = wheel_id[j + 1];
            wheel_slot[j]   = wheel_slot[j + 1];
            wheel_rounds[j] = wheel_rounds[j + 1];
        end
        wheel_live--;
    endfunction

    task automatic predict_wheel_results(input logic [CMD_W-1:0] cmd,
                                         input logic [DELAY_W-1:0] delay,
                                         input logic [ID_W-1:0] tid);
        int unsigned     slots;
        int unsigned     period;
        int unsigned     ticks;
        int unsigned     served;
        int unsigned     i;
        int unsigned     k;
        bit              found;
        logic [ID_W-1:0] fired [$];
        // out-of-range slot count clamps to 1..MAX_SLOTS, period 0 acts as 1
        slots  = (cfg_slots_q == 0) ? 1 :
                 (cfg_slots_q > MAX_SLOTS) ? MAX_SLOTS : cfg_slots_q;
        period = (cfg_period_q == 0) ? 1 : cfg_period_q;
        case (cmd)
            CMD_ADD: begin
                ticks = delay / period;
                if (wheel_live >= WHEEL_DEPTH) begin
                    // full table burns no id
                    push_result(KIND_FULL, '0, 0, 0, 1'b1);
                end else begin
                    wheel_id[wheel_live]     = wheel_next_id;
                    wheel_slot[wheel_live]   = (wheel_ptr + ticks % slots) % slots;
                    wheel_rounds[wheel_live] = ticks / slots;
                    push_result(KIND_ADDED, wheel_next_id, wheel_slot[wheel_live],
                                wheel_rounds[wheel_live], 1'b1);
                    wheel_live++;
                    wheel_next_id = (wheel_next_id == ID_LAST) ? ID_FIRST
                                                               : wheel_next_id + 1'b1;
                end
            end
            CMD_CANCEL: begin
                // oldest live match wins; id 0 never matches a live timer
                found = 1'b0;
                for (i = 0; i < wheel_live && !found; i++) begin
                    if (wheel_id[i] == tid) begin
                        remove_entry(i);
                        found = 1'b1;
                    end
                end
                push_result(found ? KIND_CANCELLED : KIND_NOT_FOUND, '0, 0, 0, 1'b1);
            end
            CMD_TICK: begin
                // serve the stored pointer even if it lies beyond the slot count
                served = wheel_ptr;
                i = 0;
                while (i < wheel_live) begin
                    if (wheel_slot[i] == served && wheel_rounds[i] == 0) begin
                        fired.push_back(wheel_id[i]);
                        remove_entry(i);
                    end else begin
                        if (wheel_slot[i] == served)
                            wheel_rounds[i] = wheel_rounds[i] - 1;
                        i++;
                    end
                end
                wheel_ptr = (served + 1) % slots;
                if (fired.size() == 0) begin
                    push_result(KIND_TICK_NONE, '0, served, 0, 1'b1);
                end else begin
                    for (k = 0; k < fired.size(); k++)
                        push_result(KIND_FIRED, fired[k], served, 0, k + 1 == fired.size());
                end
            end
            default: ;  // unused command: no result
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Items in are predicted, results out are checked, both at the rising edge.
    always @(posedge aclk) begin : monitor
        wheel_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_wheel_results(s_tuser, s_tdata[DELAY_W-1:0],
                                      s_tdata[DELAY_W +: ID_W]);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending, kind", m_tuser, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("kind", m_tuser, want.kind);
                    if (m_tdata[ID_W-1:0] != want.id)
                        report_mismatch("timer id", m_tdata[ID_W-1:0], want.id);
                    if (m_tdata[ID_W +: SLOT_W] != want.slot)
                        report_mismatch("slot", m_tdata[ID_W +: SLOT_W], want.slot);
                    if (m_tdata[ID_W + SLOT_W +: ROUNDS_W] != want.rounds)
                        report_mismatch("rounds", m_tdata[ID_W + SLOT_W +: ROUNDS_W],
                                        want.rounds);
                    if (m_tlast != want.last)
                        report_mismatch("tlast", m_tlast, want.last);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here.
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: too long without any item moving on either side.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving helpers; all start and end at a falling edge
    // ------------------------------------------------------------------
    // tvalid stays high on return so back-to-back items need no second
    // assignment in one step; anything else lowers it first.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DELAY_W-1:0] delay,
                             input logic [ID_W-1:0] tid);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, tid, delay};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Sender pauses until every predicted result is in, then lets the block settle.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Only called with the block idle, after wait_drain.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SLOT_COUNT)
            cfg_slots_q = value[SLOT_CNT_W-1:0];
        else
            cfg_period_q = value[PERIOD_W-1:0];
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: every command, field extremes, several fires in one tick.
    task automatic test_basic_ops();
        send_item(CMD_TICK, '0, '0);                    // empty wheel: nothing fired
        send_item(CMD_ADD, '0, '0);                     // zero delay
        send_item(CMD_ADD, '1, '1);                     // largest delay, most rounds
        send_item(CMD_ADD, 31'd1, 16'h8000);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '1, '1);
        send_item(CMD_CANCEL, '0, 16'd2);               // live
        send_item(CMD_CANCEL, '1, 16'd2);               // already gone
        send_item(CMD_CANCEL, '0, '0);                  // id 0 is never found
        send_item(CMD_NONE, '1, '1);                    // ignored, no result
        repeat (3) send_item(CMD_ADD, '0, '0);          // three in the same slot
        send_item(CMD_TICK, '0, '0);                    // fire in order of addition
        wait_drain();
    endtask

    // Slot count 0 and above the maximum, tick period 0 and 65535, and a
    // pointer left beyond a shrunk slot count.
    task automatic test_slot_and_period_extremes();
        write_register(REG_SLOT_COUNT, 16'd0);
        write_register(REG_TICK_PERIOD, 16'd0);
        send_item(CMD_ADD, 31'd2, 16'h5A5A);
        repeat (4) send_item(CMD_TICK, '0, '0);
        wait_drain();
        write_register(REG_SLOT_COUNT, 16'd511);
        write_register(REG_TICK_PERIOD, 16'hFFFF);
        send_item(CMD_ADD, '1, '0);
        send_item(CMD_ADD, 31'd65534, '0);
        send_item(CMD_TICK, '0, '0);                    // one fires, one loses a round
        send_item(CMD_CANCEL, '0, wheel_id[0]);
        wait_drain();
    endtask

    // Receiver holds off while adds keep coming: block stalls, table fills,
    // extra adds report full. Then drain and cancel everything at random.
    task automatic test_fill_under_backpressure();
        write_register(REG_SLOT_COUNT, SLOT_COUNT_RESET);
        write_register(REG_TICK_PERIOD, 16'd1000);
        send_gap_pct = 0;
        stall_pct    = 0;
        @(posedge aclk);
        hold_request = HOLD_CYCLES;
        @(negedge aclk);
        repeat (WHEEL_DEPTH + 2) send_item(CMD_ADD, $urandom, $urandom);
        wait_drain();
        send_gap_pct = 17;
        stall_pct    = 17;
        while (wheel_live != 0)
            send_item(CMD_CANCEL, $urandom, wheel_id[$urandom_range(wheel_live - 1, 0)]);
        wait_drain();
    endtask

    // Small wheels and short delays so timers really wrap and fire.
    task automatic test_random_mix(input int unsigned gap_pct, input int unsigned stall,
                                   input int unsigned n_items);
        int unsigned        sent;
        int unsigned        pick;
        int unsigned        slots;
        int unsigned        period;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    tid;
        write_register(REG_SLOT_COUNT, $urandom_range(12, 1));
        write_register(REG_TICK_PERIOD, $urandom_range(4, 0));
        slots        = cfg_slots_q;
        period       = (cfg_period_q == 0) ? 1 : cfg_period_q;
        send_gap_pct = gap_pct;
        stall_pct    = stall;
        sent         = 0;
        while (sent < n_items) begin
            pick  = $urandom_range(99);
            delay = $urandom;
            tid   = $urandom;
            if (pick < 42) begin
                // mostly delays of up to three turns, now and then the full range
                if ($urandom_range(9) != 0)
                    delay = period * $urandom_range(3 * slots, 0) + $urandom_range(period - 1, 0);
                send_item(CMD_ADD, delay, tid);
                sent++;
            end else if (pick < 62) begin
                if (wheel_live != 0 && $urandom_range(3) != 0)
                    tid = wheel_id[$urandom_range(wheel_live - 1, 0)];
                send_item(CMD_CANCEL, delay, tid);
                sent++;
            end else if (pick < 96) begin
                send_item(CMD_TICK, delay, tid);
                sent++;
            end else begin
                send_item(CMD_NONE, delay, tid);
            end
        end
        wait_drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_basic_ops();
        test_slot_and_period_extremes();
        test_fill_under_backpressure();
        test_random_mix(0, 0, RANDOM_ITEMS);
        test_random_mix(48, 0, RANDOM_ITEMS);
        test_random_mix(0, 48, RANDOM_ITEMS);
        test_random_mix(17, 17, RANDOM_ITEMS);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/hwu_pkg.sv
src/hwu_divider.sv
src/hashed_timing_wheel_unit.sv
src/hwu_checker.sv
tb/hashed_timing_wheel_unit_tb.sv
